### hdl/gcode_line_framer_with_resend_macros.svh
// assertion macros for the gcode line framer
`ifndef GCODE_LINE_FRAMER_WITH_RESEND_MACROS_SVH
`define GCODE_LINE_FRAMER_WITH_RESEND_MACROS_SVH

// implication checked every cycle outside reset
`define GLF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked on the following cycle
`define GLF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/glf_pkg.sv
// shared types and constants for the gcode line framer
package glf_pkg;
  localparam int unsigned LineCapacity = 40;
  localparam int unsigned NumberBits   = 31;
  localparam int unsigned LenW         = $clog2(LineCapacity + 1);
  localparam int unsigned AddrW        = $clog2(LineCapacity);

  // decimal conversion: digit width, most digits of a number, digit count width
  localparam int unsigned DigW         = 4;
  localparam int unsigned MaxDigits    = 10;
  localparam int unsigned CntW         = $clog2(MaxDigits + 1);
  // exact v/10 for any 32-bit v: (v * Recip10) >> Recip10Shift
  localparam logic [31:0] Recip10      = 32'hcccc_cccd;
  localparam int unsigned Recip10Shift = 35;

  localparam logic       OP_CHAR   = 1'b0;
  localparam logic       OP_RESEND = 1'b1;
  localparam logic [7:0] CH_N      = 8'h4e;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] BYTE_MASK = 8'hff;

  typedef struct packed {
    logic       operation;
    logic [7:0] char_in;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       run_last;
    logic       overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_PFX_N, ST_PFX_CONV, ST_PFX_DIG, ST_PFX_SP,
    ST_TXT_SP, ST_TXT_CH, ST_RPL_RD, ST_RPL_OUT, ST_SFX_STAR, ST_SFX_CONV,
    ST_SFX_DIG, ST_SFX_LF, ST_DONE
  } state_t;

  // byte selection for the output stage
  typedef enum logic [2:0] {
    SEL_N, SEL_SPACE, SEL_DIGIT, SEL_CHAR, SEL_STORE, SEL_STAR, SEL_LF
  } sel_t;

  typedef struct packed {
    logic       latch_in;
    logic       new_line;
    logic       conv_start;
    logic       conv_cs;
    logic       conv_step;
    logic       digit_pop;
    logic       emit;
    sel_t       sel;
    logic       fold;
    logic       store_wr;
    logic       rd_start;
    logic       rd_next;
    logic       set_ovf;
    logic       clr_space;
    logic       set_space;
    logic       close_line;
    logic       last;
  } cmd_t;

  typedef struct packed {
    in_item_t item;
    logic     is_space;
    logic     prefix_sent;
    logic     space_pending;
    logic     overflowed;
    logic     fits;
    logic     len_zero;
    logic     conv_done;
    logic     digits_left;
    logic     rd_more;
    logic     out_busy;
  } stat_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction
endpackage

### hdl/glf_ctrl.sv
// controller state machine for the gcode line framer
module glf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  glf_pkg::stat_t   st,
  output glf_pkg::cmd_t    cmd
);
  import glf_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = SEL_N;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (st.item.operation == OP_RESEND) begin
          if (st.prefix_sent) state_nxt = ST_IDLE;
          else                state_nxt = ST_PFX_N;
        end else if (!st.prefix_sent) begin
          cmd.new_line = 1'b1;
          state_nxt    = ST_PFX_N;
        end else if (st.is_space) begin
          if (!st.len_zero) cmd.set_space = 1'b1;
          state_nxt = ST_TXT_SP;
        end else begin
          state_nxt = ST_TXT_SP;
        end
      end
      ST_PFX_N: if (!st.out_busy) begin
        cmd.emit = 1'b1; cmd.sel = SEL_N; cmd.fold = 1'b1;
        cmd.conv_start = 1'b1;
        state_nxt = ST_PFX_CONV;
      end
      ST_PFX_CONV: begin
        cmd.conv_step = 1'b1;
        if (st.conv_done) state_nxt = ST_PFX_DIG;
      end
      ST_PFX_DIG: if (!st.out_busy) begin
        cmd.emit = 1'b1; cmd.sel = SEL_DIGIT; cmd.fold = 1'b1; cmd.digit_pop = 1'b1;
        if (!st.digits_left) state_nxt = ST_PFX_SP;
      end
      ST_PFX_SP: if (!st.out_busy) begin
        cmd.emit = 1'b1; cmd.sel = SEL_SPACE; cmd.fold = 1'b1;
        if (st.item.operation == OP_RESEND) begin
          cmd.rd_start = 1'b1;
          state_nxt = ST_RPL_RD;
        end else begin
          // leading whitespace on a line that stays open ends the request here
          cmd.last  = st.is_space && !st.item.line_end;
          state_nxt = ST_TXT_SP;
        end
      end
      // text path: possibly a pending space then the character
      ST_TXT_SP: begin
        if (st.is_space || st.overflowed) begin
          state_nxt = st.item.line_end ? ST_SFX_STAR : ST_DONE;
        end else if (!st.fits) begin
          cmd.set_ovf = 1'b1;
          state_nxt = st.item.line_end ? ST_SFX_STAR : ST_DONE;
        end else if (st.space_pending) begin
          if (!st.out_busy) begin
            cmd.emit = 1'b1; cmd.sel = SEL_SPACE; cmd.fold = 1'b1;
            cmd.store_wr = 1'b1; cmd.clr_space = 1'b1;
            state_nxt = ST_TXT_CH;
          end
        end else begin
          state_nxt = ST_TXT_CH;
        end
      end
      ST_TXT_CH: if (!st.out_busy) begin
        cmd.emit = 1'b1; cmd.sel = SEL_CHAR; cmd.fold = 1'b1; cmd.store_wr = 1'b1;
        cmd.last = !st.item.line_end;
        state_nxt = st.item.line_end ? ST_SFX_STAR : ST_IDLE;
      end
      ST_RPL_RD: begin
        state_nxt = st.rd_more ? ST_RPL_OUT : ST_SFX_STAR;
      end
      ST_RPL_OUT: if (!st.out_busy) begin
        cmd.emit = 1'b1; cmd.sel = SEL_STORE; cmd.fold = 1'b1; cmd.rd_next = 1'b1;
        state_nxt = ST_RPL_RD;
      end
      ST_SFX_STAR: if (!st.out_busy) begin
        cmd.emit = 1'b1; cmd.sel = SEL_STAR;
        cmd.conv_start = 1'b1; cmd.conv_cs = 1'b1;
        state_nxt = ST_SFX_CONV;
      end
      ST_SFX_CONV: begin
        cmd.conv_step = 1'b1;
        if (st.conv_done) state_nxt = ST_SFX_DIG;
      end
      ST_SFX_DIG: if (!st.out_busy) begin
        cmd.emit = 1'b1; cmd.sel = SEL_DIGIT; cmd.digit_pop = 1'b1;
        if (!st.digits_left) state_nxt = ST_SFX_LF;
      end
      ST_SFX_LF: if (!st.out_busy) begin
        cmd.emit = 1'b1; cmd.sel = SEL_LF; cmd.last = 1'b1;
        if (st.item.operation == OP_CHAR) cmd.close_line = 1'b1;
        state_nxt = ST_IDLE;
      end
      // item ended without a closing byte
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `include "gcode_line_framer_with_resend_macros.svh"
  `GLF_ASSERT_IMP(a_ready_idle, in_ready, state_r == ST_IDLE, "ready outside idle")
  `GLF_ASSERT_IMP(a_emit_ready, cmd.emit, !st.out_busy, "emit into a full output")
  `GLF_ASSERT_NEXT(a_latch_decode, cmd.latch_in, state_r == ST_DECODE, "no decode after accept")
endmodule

### hdl/glf_datapath.sv
// datapath: line state, text store, decimal conversion and output register
module glf_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  glf_pkg::in_item_t   in_item,
  input  glf_pkg::cmd_t       cmd,
  output glf_pkg::stat_t      st,
  output logic                out_valid,
  input  logic                out_ready,
  output glf_pkg::out_item_t  out_item
);
  import glf_pkg::*;

  in_item_t              item_r;
  logic [NumberBits-1:0] line_ctr_r;
  logic [7:0]            xor_r;
  logic                  star_r, space_r, prefix_r, ovf_r;
  logic [LenW-1:0]       len_r;
  logic [7:0]            store_mem [LineCapacity];
  logic [7:0]            rd_data_r;
  logic [LenW-1:0]       rd_idx_r;
  // decimal conversion: one digit per cycle
  logic [NumberBits-1:0] conv_val_r;
  logic [DigW-1:0]       dig_r [MaxDigits];
  logic [CntW-1:0]       dig_cnt_r;
  // output register
  out_item_t             hold_r;
  logic                  hold_v_r;

  logic [7:0]            byte_sel;
  logic [NumberBits-1:0] quot;
  logic [DigW-1:0]       rem;
  logic [63:0]           recip;

  // v/10 by reciprocal multiply, remainder by shift and subtract
  always_comb begin
    recip = 64'({1'b0, conv_val_r}) * 64'(Recip10);
    quot  = NumberBits'(recip >> Recip10Shift);
    rem   = DigW'(conv_val_r - ((quot << 3) + (quot << 1)));
  end

  always_comb begin
    case (cmd.sel)
      SEL_N:     byte_sel = CH_N;
      SEL_SPACE: byte_sel = CH_SPACE;
      SEL_DIGIT: byte_sel = CH_ZERO + {4'd0, dig_r[CntW'(dig_cnt_r - 1'b1)]};
      SEL_CHAR:  byte_sel = item_r.char_in;
      SEL_STORE: byte_sel = rd_data_r;
      SEL_STAR:  byte_sel = CH_STAR;
      SEL_LF:    byte_sel = CH_LF;
      default:   byte_sel = CH_LF;
    endcase
  end

  always_comb begin
    st.item          = item_r;
    st.is_space      = is_ws(item_r.char_in);
    st.prefix_sent   = prefix_r;
    st.space_pending = space_r;
    st.overflowed    = ovf_r;
    st.fits          = ({1'b0, len_r} + (space_r ? (LenW + 1)'(2) : (LenW + 1)'(1)))
                       <= (LenW + 1)'(LineCapacity);
    st.len_zero      = (len_r == '0);
    st.conv_done     = (conv_val_r == '0);
    st.digits_left   = (dig_cnt_r > CntW'(1));
    st.rd_more       = (rd_idx_r < len_r);
    st.out_busy      = hold_v_r && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.store_wr && len_r < LenW'(LineCapacity))
      store_mem[AddrW'(len_r)] <= (cmd.sel == SEL_SPACE) ? CH_SPACE : item_r.char_in;
    rd_data_r <= store_mem[AddrW'(rd_idx_r)];
    if (cmd.latch_in) item_r <= in_item;
  end

  always_ff @(posedge clk) begin
    if (cmd.conv_start) begin
      conv_val_r <= cmd.conv_cs ? NumberBits'(xor_r & BYTE_MASK) : line_ctr_r;
      dig_cnt_r  <= '0;
    end else if (cmd.conv_step && conv_val_r != '0 || cmd.conv_step && dig_cnt_r == '0) begin
      dig_r[dig_cnt_r[$clog2(MaxDigits)-1:0]] <= rem;
      dig_cnt_r  <= dig_cnt_r + 1'b1;
      conv_val_r <= quot;
    end else if (cmd.digit_pop) begin
      dig_cnt_r <= dig_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_ctr_r <= '0; xor_r <= '0; star_r <= 1'b0; space_r <= 1'b0;
      prefix_r <= 1'b0; ovf_r <= 1'b0; len_r <= '0; rd_idx_r <= '0;
      hold_v_r <= 1'b0;
    end else begin
      if (cmd.new_line) begin
        line_ctr_r <= line_ctr_r + 1'b1;
        space_r <= 1'b0; len_r <= '0; ovf_r <= 1'b0; prefix_r <= 1'b1;
      end
      if (cmd.sel == SEL_N && cmd.emit) begin
        xor_r <= CH_N; star_r <= 1'b0;
      end else if (cmd.emit && cmd.fold && !star_r) begin
        if (byte_sel == CH_STAR) star_r <= 1'b1;
        else                     xor_r  <= xor_r ^ byte_sel;
      end
      if (cmd.set_space) space_r <= 1'b1;
      if (cmd.clr_space) space_r <= 1'b0;
      if (cmd.emit && cmd.sel == SEL_CHAR) space_r <= 1'b0;
      if (cmd.store_wr) len_r <= len_r + 1'b1;
      if (cmd.set_ovf) ovf_r <= 1'b1;
      if (cmd.close_line) begin
        prefix_r <= 1'b0; space_r <= 1'b0;
      end
      if (cmd.rd_start) rd_idx_r <= '0;
      if (cmd.rd_next)  rd_idx_r <= rd_idx_r + 1'b1;
      // output register: loaded by an emit, emptied once taken
      if (cmd.emit) begin
        hold_r.char_out <= byte_sel;
        hold_r.run_last <= cmd.last;
        hold_r.overflow <= ovf_r;
        hold_v_r <= 1'b1;
      end else if (out_ready) begin
        hold_v_r <= 1'b0;
      end
    end
  end

  assign out_valid = hold_v_r;
  assign out_item  = hold_r;

  `include "gcode_line_framer_with_resend_macros.svh"
  `GLF_ASSERT_IMP(a_len_cap, 1'b1, len_r <= LenW'(LineCapacity), "text length past capacity")
  `GLF_ASSERT_NEXT(a_out_hold, hold_v_r && !out_ready, hold_v_r && $stable(hold_r), "output changed while waiting")
  `GLF_ASSERT_IMP(a_store_room, cmd.store_wr, len_r < LenW'(LineCapacity), "write past store")
endmodule

### hdl/gcode_line_framer_with_resend.sv
// top level of the gcode line framer with resend
// Takes command characters one request at a time and sends the framed line
// "N<n> <text>*<cs>\n" one byte per output request. Whitespace is simplified,
// the line number rises per line and the checksum is the XOR of all bytes
// before the first '*'. A resend request replays the stored text under the
// same number when no line is open; while a line is open it is ignored. A
// request is accepted and decoded, then each byte produced enters the output
// register, waiting while that register is still full; a text character first
// passes a decision step, a replay reads each stored byte before sending it,
// and each decimal number is taken apart digit by digit before its digits go
// out, most significant first. A new request is taken only once the
// controller has returned to idle.
module gcode_line_framer_with_resend (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  glf_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output glf_pkg::out_item_t  out_data
);
  import glf_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // sequencing of prefix, text, replay and suffix
  glf_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .st, .cmd
  );

  // line state, store, digit unit and output register
  glf_datapath u_dp (
    .clk, .rst_n, .in_item(in_data), .cmd, .st,
    .out_valid, .out_ready, .out_item(out_data)
  );
endmodule

### dv/tb_top.sv
// testbench for the gcode line framer with resend
`timescale 1ns / 100ps

module tb_top;
  import glf_pkg::*;

  localparam int unsigned RandomItems = 290;
  localparam int unsigned StallLimit  = 20000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  gcode_line_framer_with_resend u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // framer shadow state; line number and checksum kept at the block's widths
  logic [NumberBits-1:0] line_num;
  logic [7:0]            cs_acc;
  logic                  star_hit;
  logic                  gap_pending;
  logic                  line_open;
  logic [7:0]            text_mem [LineCapacity];
  int unsigned           text_len;
  logic                  dropped;

  // expected output bytes, oldest first
  out_item_t framed_q[$];
  out_item_t item_bytes[$];

  int unsigned errors;
  int unsigned bytes_seen;
  int unsigned lines_sent;
  int unsigned resends_sent;
  int unsigned drop_lines;
  logic        quiet;

  function automatic logic ws_char(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // push one framed byte, folding into the checksum when asked
  function automatic void emit_byte(input logic [7:0] c, input logic fold_it);
    out_item_t b;
    if (fold_it && !star_hit) begin
      if (c == CH_STAR) star_hit = 1'b1;
      else cs_acc ^= c;
    end
    b.char_out = c;
    b.run_last = 1'b0;
    b.overflow = 1'b0;
    item_bytes.push_back(b);
  endfunction

  function automatic void emit_decimal(input logic [31:0] v, input logic fold_it);
    logic [7:0] digs[$];
    digs = {};
    do begin
      digs.push_front(CH_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digs[i]) emit_byte(digs[i], fold_it);
  endfunction

  function automatic void emit_prefix();
    cs_acc   = 8'h00;
    star_hit = 1'b0;
    emit_byte(CH_N, 1'b1);
    emit_decimal(32'(line_num), 1'b1);
    emit_byte(CH_SPACE, 1'b1);
  endfunction

  function automatic void emit_suffix();
    logic [7:0] cs;
    cs = cs_acc & BYTE_MASK;
    emit_byte(CH_STAR, 1'b0);
    emit_decimal(32'(cs), 1'b0);
    emit_byte(CH_LF, 1'b0);
  endfunction

  function automatic void emit_text(input logic [7:0] c);
    if (text_len < LineCapacity) text_mem[text_len] = c;
    text_len++;
    emit_byte(c, 1'b1);
  endfunction

  // work out the bytes one request produces and queue them
  function automatic void frame_request(input in_item_t it);
    int unsigned need;
    item_bytes = {};
    if (it.operation == OP_RESEND) begin
      if (!line_open) begin
        emit_prefix();
        for (int unsigned i = 0; i < text_len && i < LineCapacity; i++)
          emit_byte(text_mem[i], 1'b1);
        emit_suffix();
        resends_sent++;
      end
    end else begin
      if (!line_open) begin
        line_num++;
        gap_pending = 1'b0;
        text_len    = 0;
        dropped     = 1'b0;
        line_open   = 1'b1;
        emit_prefix();
      end
      if (ws_char(it.char_in)) begin
        if (text_len > 0) gap_pending = 1'b1;
      end else if (!dropped) begin
        need = gap_pending ? 2 : 1;
        if (text_len + need <= LineCapacity) begin
          if (gap_pending) emit_text(CH_SPACE);
          emit_text(it.char_in);
          gap_pending = 1'b0;
        end else begin
          dropped = 1'b1;
        end
      end
      if (it.line_end) begin
        emit_suffix();
        line_open   = 1'b0;
        gap_pending = 1'b0;
        lines_sent++;
        if (dropped) drop_lines++;
      end
    end
    foreach (item_bytes[i]) begin
      item_bytes[i].run_last = (i == item_bytes.size() - 1);
      item_bytes[i].overflow = dropped;
      framed_q.push_back(item_bytes[i]);
    end
  endfunction

  // directed table: op, char, end, and where obvious the full expected frame
  typedef struct {
    logic       op;
    logic [7:0] ch;
    logic       lend;
    string      frame;
  } row_t;

  row_t dir_rows[$];

  function automatic void add_row(input logic op, input logic [7:0] ch, input logic lend,
                                  input string frame = "");
    row_t r;
    r.op = op; r.ch = ch; r.lend = lend; r.frame = frame;
    dir_rows.push_back(r);
  endfunction

  // checksum of "N0 " is 'N'^'0'^' ' = 0x5e = 94
  initial begin
    add_row(OP_RESEND, 8'h00, 1'b0, "N0 *94\n");   // resend before any line
    add_row(OP_CHAR,   8'h20, 1'b1);                // empty line, only whitespace
    add_row(OP_CHAR,   8'h09, 1'b0);                // leading whitespace dropped
    add_row(OP_CHAR,   "G",   1'b0);
    add_row(OP_CHAR,   8'h0d, 1'b0);                // internal run collapses
    add_row(OP_CHAR,   8'h20, 1'b0);
    add_row(OP_CHAR,   "1",   1'b0);
    add_row(OP_RESEND, 8'hff, 1'b1);                // ignored while line open
    add_row(OP_CHAR,   "*",   1'b0);                // star ends the checksum
    add_row(OP_CHAR,   8'hff, 1'b0);
    add_row(OP_CHAR,   8'h00, 1'b0);
    add_row(OP_CHAR,   8'h0c, 1'b1);                // trailing whitespace dropped
    add_row(OP_RESEND, 8'h00, 1'b0);                // replay of the last line
    add_row(OP_CHAR,   8'h80, 1'b1);                // one-byte line, high bit set
    add_row(OP_CHAR,   8'h7f, 1'b0);
    add_row(OP_CHAR,   8'h0a, 1'b0);
    add_row(OP_CHAR,   8'h0b, 1'b0);
    add_row(OP_CHAR,   8'h01, 1'b1);
    add_row(OP_RESEND, 8'h00, 1'b1);
  end

  // sender side: in_valid held until accepted, random gaps between requests
  logic in_fire;
  assign in_fire = in_valid && in_ready;

  task automatic send_request(input in_item_t it);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    frame_request(it);
  endtask

  // receiver side: ready drops in random bursts unless in the quiet tail
  always @(posedge clk) begin : recv_stall
    int unsigned hold;
    if (!rst_n) begin
      out_ready <= 1'b1;
      hold = 0;
    end else if (hold > 0) begin
      hold--;
      if (hold == 0) out_ready <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      hold = $urandom_range(1, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare each accepted byte against the oldest expectation
  always @(posedge clk) begin : byte_check
    out_item_t exp_b;
    if (rst_n && out_valid && out_ready) begin
      bytes_seen++;
      if (framed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte expected none actual %h/%b/%b", $time,
                 out_data.char_out, out_data.run_last, out_data.overflow);
      end else begin
        exp_b = framed_q[0];
        framed_q.delete(0);
        if (out_data.char_out !== exp_b.char_out) begin
          errors++;
          $display("%0t: char_out expected %h actual %h", $time,
                   exp_b.char_out, out_data.char_out);
        end
        if (out_data.run_last !== exp_b.run_last) begin
          errors++;
          $display("%0t: run_last expected %b actual %b", $time,
                   exp_b.run_last, out_data.run_last);
        end
        if (out_data.overflow !== exp_b.overflow) begin
          errors++;
          $display("%0t: overflow expected %b actual %b", $time,
                   exp_b.overflow, out_data.overflow);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  int unsigned idle_cycles;
  always @(posedge clk) begin
    if (!rst_n || in_fire || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // random character: mostly printable, some whitespace, a few stars and odd bytes
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1:    return ws_char(8'($urandom_range(9, 13))) ? 8'($urandom_range(9, 13)) : CH_SPACE;
      2:       return CH_SPACE;
      3:       return ($urandom_range(0, 3) == 0) ? CH_STAR : 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(33, 126));
    endcase
  endfunction

  initial begin : stim
    in_item_t   it;
    row_t       r;
    int unsigned line_len;
    int unsigned sent;
    int unsigned k;
    int unsigned tail;
    string      got;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    quiet     = 1'b0;
    errors    = 0;
    bytes_seen = 0; lines_sent = 0; resends_sent = 0; drop_lines = 0;
    line_num  = '0; cs_acc = 8'h00; star_hit = 1'b0; gap_pending = 1'b0;
    line_open = 1'b0; text_len = 0; dropped = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; where a frame is typed in, the prediction is checked against it
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      it.operation = r.op;
      it.char_in   = r.ch;
      it.line_end  = r.lend;
      send_request(it);
      if (r.frame.len() > 0) begin
        got = "";
        foreach (item_bytes[j]) got = {got, string'(item_bytes[j].char_out)};
        if (got != r.frame) begin
          errors++;
          $display("%0t: frame expected %s actual %s", $time, r.frame, got);
        end
      end
    end

    // random lines: mostly well-formed, a few long enough to overflow
    sent = 0;
    while (sent < RandomItems) begin
      if (sent > RandomItems - 40) quiet = 1'b1;
      if ($urandom_range(0, 5) == 0) begin
        it.operation = OP_RESEND;
        it.char_in   = 8'($urandom_range(0, 255));
        it.line_end  = 1'($urandom_range(0, 1));
        send_request(it);
        sent++;
        continue;
      end
      line_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 52) : $urandom_range(1, 12);
      for (k = 0; k < line_len; k++) begin
        it.operation = OP_CHAR;
        it.char_in   = pick_char();
        it.line_end  = (k == line_len - 1);
        // occasionally slip a resend into an open line
        if (k > 0 && $urandom_range(0, 19) == 0) begin
          in_item_t rs;
          rs.operation = OP_RESEND;
          rs.char_in   = 8'($urandom_range(0, 255));
          rs.line_end  = 1'($urandom_range(0, 1));
          send_request(rs);
          sent++;
        end
        send_request(it);
        sent++;
      end
    end
    in_valid <= 1'b0;

    // drain: wait until every expected byte has left, then a short settle
    tail = 0;
    while (framed_q.size() != 0 && tail < StallLimit) begin
      @(posedge clk);
      tail++;
    end
    repeat (64) @(posedge clk);

    $display("covered %0d lines (%0d with dropped text) and %0d resends", lines_sent,
             drop_lines, resends_sent);
    $display("checked %0d framed bytes, %0d left waiting", bytes_seen, framed_q.size());
    if (errors == 0 && framed_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
